/* sv/vbd_pkg.sv */
// video1 block decoder package: shared types, stream constants and color expansion
// used by vbd_ctrl, vbd_datapath and the video1_block_decoder top level
`timescale 1ns / 1ps
`default_nettype none

package vbd_pkg;

    // stream word decoding
    localparam logic [15:0] SKIP_MASK = 16'hFC00;
    localparam logic [15:0] SKIP_CODE = 16'h8400;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // configuration register indexes
    localparam logic CFG_WIDTH_IDX  = 1'b0;
    localparam logic CFG_HEIGHT_IDX = 1'b1;
    localparam int   CFG_DATA_W     = 9;

    // result kinds
    localparam logic KIND_PIXEL_ROW    = 1'b0;
    localparam logic KIND_END_OF_FRAME = 1'b1;

    // result payload widths
    localparam int PIXEL_ROW_W = 10;
    localparam int BLOCK_COL_W = 8;
    localparam int PIXEL_W     = 32;
    localparam int M_FIELDS_W  = PIXEL_ROW_W + BLOCK_COL_W + 4 * PIXEL_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic       capture;
        logic       finish_frame;
        logic       start_skip;
        logic       skip_step;
        logic       store_mask;
        logic       store_first;
        logic       store_color;
        logic       advance_block;
        logic       load_row;
        logic       load_marker;
        logic       row_last;
        logic [1:0] row_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_finished;
        logic row_ge_h;
        logic wp_zero;
        logic wp_one;
        logic wp_two;
        logic wp_eight;
        logic eight_mode;
        logic word_is_skip;
        logic word_is_fill;
        logic col_ge_w;
        logic skip_ends_frame;
        logic block_ends_frame;
        logic slot_free;
    } dp_status_t;

    // rgb555 to argb8888, low bits of each channel zero
    function automatic logic [31:0] expand555(input logic [14:0] c);
        expand555 = {ALPHA_OPAQUE, c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
    endfunction

endpackage

`default_nettype wire

/* sv/video1_block_decoder.sv */
// a word is captured in ST_IDLE and decoded in ST_DECODE; a block's rows are then
// loaded into the output register from ST_EMIT, one row per cycle unless m_tready stalls.
// s_tready is high only in ST_IDLE, so no new word is taken until the last one has
// been decoded and its rows, end-of-frame marker or skip row wraps are done.
// reset: aresetn low clears parser, cursor, output valid and sets geometry to 80x60.
// video1 block decoder top level: joins vbd_ctrl and vbd_datapath, depends on vbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module video1_block_decoder
    import vbd_pkg::*;
#(
    parameter int MAX_BLOCK_COLUMNS = 256,
    parameter int MAX_BLOCK_ROWS    = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config write port
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,  // code_word
    input  wire logic                  s_tuser,  // frame_start
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pixel_row, block_column, pixel_a, pixel_b, pixel_c, pixel_d, zero pad
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tuser,  // kind
    output logic                       m_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;

    vbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vbd_datapath #(
        .MAX_BLOCK_COLUMNS (MAX_BLOCK_COLUMNS),
        .MAX_BLOCK_ROWS    (MAX_BLOCK_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

/* sv/vbd_ctrl.sv */
// video1 block decoder controller: word parser and result sequencing state machine
// depends on vbd_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module vbd_ctrl
    import vbd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SKIP   = 3'd2;
    localparam logic [2:0] ST_EMIT   = 3'd3;
    localparam logic [2:0] ST_MARKER = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] row_cnt_reg, row_cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        cmd          = '0;
        cmd.row_sel  = row_cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                row_cnt_next = 2'd0;
                if (status.frame_finished) begin
                    state_next = ST_IDLE;
                end else if (status.row_ge_h) begin
                    // height shrank under the cursor
                    cmd.finish_frame = 1'b1;
                    state_next       = ST_MARKER;
                end else if (status.wp_zero) begin
                    if (status.word_is_skip) begin
                        cmd.start_skip = 1'b1;
                        state_next     = ST_SKIP;
                    end else if (status.word_is_fill) begin
                        state_next = ST_EMIT;
                    end else begin
                        cmd.store_mask = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (status.wp_one) begin
                    cmd.store_first = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    cmd.store_color = 1'b1;
                    if ((status.wp_two && !status.eight_mode) || status.wp_eight) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SKIP: begin
                // one row wrap per cycle
                if (status.col_ge_w) begin
                    cmd.skip_step = 1'b1;
                    if (status.skip_ends_frame) begin
                        state_next = ST_MARKER;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (status.slot_free) begin
                    cmd.load_row = 1'b1;
                    row_cnt_next = row_cnt_reg + 2'd1;
                    if (row_cnt_reg == 2'd3) begin
                        cmd.row_last      = !status.block_ends_frame;
                        cmd.advance_block = 1'b1;
                        state_next = status.block_ends_frame ? ST_MARKER : ST_IDLE;
                    end
                end
            end
            ST_MARKER: begin
                if (status.slot_free) begin
                    cmd.load_marker = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_cnt_reg <= 2'd0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

`default_nettype wire

/* sv/vbd_datapath.sv */
// video1 block decoder datapath: parser state, color store, block cursor, output register
// depends on vbd_pkg; driven by vbd_ctrl through dp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module vbd_datapath
    import vbd_pkg::*;
#(
    parameter int MAX_BLOCK_COLUMNS = 256,
    parameter int MAX_BLOCK_ROWS    = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [15:0]           s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    localparam int CW = $clog2(MAX_BLOCK_COLUMNS + 1024);
    localparam int WW = $clog2(MAX_BLOCK_COLUMNS + 1);
    localparam int HW = $clog2(MAX_BLOCK_ROWS + 1);
    localparam int PW = (HW > 8) ? HW : 8;

    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic [15:0]           word_reg;
    logic [3:0]            wp_reg;
    logic [15:0]           mask_reg;
    logic [7:0][14:0]      color_reg;
    logic                  mode_reg;
    logic [CW-1:0]         col_reg;
    logic [HW-1:0]         row_reg;
    logic                  finished_reg;

    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic                  out_last_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] col_inc;
    logic          col_wrap;
    logic [HW:0]   row_inc;
    logic          row_ends;
    logic [PW-1:0] row_base;
    logic [2:0]    wr_idx;
    logic          slot_free;
    logic [PIXEL_W-1:0] px [4];
    logic [M_TDATA_W-1:0] row_data;

    // geometry clamp: zero acts as one, oversize saturates
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > 32'(MAX_BLOCK_COLUMNS)) begin
            w_eff = WW'(MAX_BLOCK_COLUMNS);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > 32'(MAX_BLOCK_ROWS)) begin
            h_eff = HW'(MAX_BLOCK_ROWS);
        end else begin
            h_eff = HW'(height_reg);
        end
    end

    assign col_inc   = col_reg + CW'(1);
    assign col_wrap  = (col_inc >= CW'(w_eff));
    assign row_inc   = {1'b0, row_reg} + (HW + 1)'(1);
    assign row_ends  = (row_inc >= {1'b0, h_eff});
    assign row_base  = PW'(h_eff) - PW'(row_reg) - PW'(1);
    assign wr_idx    = 3'(wp_reg - 4'd1);
    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        status.frame_finished   = finished_reg;
        status.row_ge_h         = (row_reg >= h_eff);
        status.wp_zero          = (wp_reg == 4'd0);
        status.wp_one           = (wp_reg == 4'd1);
        status.wp_two           = (wp_reg == 4'd2);
        status.wp_eight         = (wp_reg == 4'd8);
        status.eight_mode       = mode_reg;
        status.word_is_skip     = ((word_reg & SKIP_MASK) == SKIP_CODE);
        status.word_is_fill     = word_reg[15];
        status.col_ge_w         = (col_reg >= CW'(w_eff));
        status.skip_ends_frame  = row_ends;
        status.block_ends_frame = col_wrap && row_ends;
        status.slot_free        = slot_free;
    end

    // pixel row select: mask rows run bottom-up, fill uses the first word
    always_comb begin
        logic [1:0] g;
        logic [1:0] xb;
        logic       mbit;
        logic [2:0] sel;
        g = ~cmd.row_sel;
        for (int x = 0; x < 4; x++) begin
            xb   = 2'(x);
            mbit = mask_reg[{g, xb}];
            sel  = mode_reg ? {g[1], xb[1], ~mbit} : {2'b00, ~mbit};
            if (wp_reg == 4'd0) begin
                px[x] = expand555(word_reg[14:0]);
            end else begin
                px[x] = expand555(color_reg[sel]);
            end
        end
        row_data = M_TDATA_W'({px[3], px[2], px[1], px[0], col_reg[7:0],
                               row_base[7:0], cmd.row_sel});
    end

    // parser and cursor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= CFG_DATA_W'(80);
            height_reg   <= CFG_DATA_W'(60);
            wp_reg       <= 4'd0;
            mask_reg     <= 16'd0;
            mode_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            finished_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_WIDTH_IDX:  width_reg  <= cfg_wdata;
                    CFG_HEIGHT_IDX: height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.capture && s_tuser) begin
                wp_reg       <= 4'd0;
                mask_reg     <= 16'd0;
                mode_reg     <= 1'b0;
                col_reg      <= '0;
                row_reg      <= '0;
                finished_reg <= 1'b0;
            end
            if (cmd.finish_frame) begin
                finished_reg <= 1'b1;
                wp_reg       <= 4'd0;
            end
            if (cmd.start_skip) begin
                col_reg <= col_reg + CW'(word_reg[9:0]);
            end
            if (cmd.skip_step) begin
                col_reg <= col_reg - CW'(w_eff);
                row_reg <= row_inc[HW-1:0];
                if (row_ends) begin
                    finished_reg <= 1'b1;
                end
            end
            if (cmd.store_mask) begin
                mask_reg <= word_reg;
                wp_reg   <= 4'd1;
            end
            if (cmd.store_first) begin
                mode_reg <= word_reg[15];
                wp_reg   <= 4'd2;
            end
            if (cmd.store_color) begin
                wp_reg <= wp_reg + 4'd1;
            end
            if (cmd.advance_block) begin
                wp_reg <= 4'd0;
                if (col_wrap) begin
                    col_reg <= '0;
                    row_reg <= row_inc[HW-1:0];
                    if (row_ends) begin
                        finished_reg <= 1'b1;
                    end
                end else begin
                    col_reg <= col_inc;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            word_reg <= s_tdata;
        end
        if (cmd.store_first) begin
            color_reg[0] <= word_reg[14:0];
        end
        if (cmd.store_color) begin
            color_reg[wr_idx] <= word_reg[14:0];
        end
        if (cmd.load_row) begin
            out_data_reg <= row_data;
            out_kind_reg <= KIND_PIXEL_ROW;
            out_last_reg <= cmd.row_last;
        end else if (cmd.load_marker) begin
            out_data_reg <= '0;
            out_kind_reg <= KIND_END_OF_FRAME;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_row || cmd.load_marker) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
